FILE: hdl/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg: shared definitions for the sector cache directory
// field widths, request kinds, response codes and parameter defaults
// ----------------------------------------------------------------------------
package scd_pkg;

    localparam int ENTRIES_DEF     = 64;
    localparam int SECTOR_BITS_DEF = 32;
    localparam int MAX_READERS_DEF = 255;

    localparam int KIND_W   = 2;
    localparam int SECTOR_W = 32;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOCK   = 2'd0,
        KIND_UNLOCK = 2'd1,
        KIND_FREE   = 2'd2,
        KIND_FLUSH  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED = 2'd0,
        ST_RETRY   = 2'd1,
        ST_BUSY    = 2'd2,
        ST_DONE    = 2'd3
    } status_t;

endpackage

FILE: hdl/scd_if.sv
// ----------------------------------------------------------------------------
// scd request and response channels
// valid/ready handshake, a request moves when both are high at a clock edge
// ----------------------------------------------------------------------------
interface scd_req_if;
    import scd_pkg::*;

    logic                valid;
    logic                ready;
    kind_t               kind;
    logic [SECTOR_W-1:0] sector;
    logic                exclusive;
    logic [SLOT_W-1:0]   slot;
    logic                mark_dirty;

    modport source (output valid, output kind, output sector, output exclusive,
                    output slot, output mark_dirty, input ready);
    modport sink   (input valid, input kind, input sector, input exclusive,
                    input slot, input mark_dirty, output ready);
endinterface

interface scd_rsp_if;
    import scd_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic [SLOT_W-1:0]   granted_slot;
    logic                need_fill;
    logic                writeback_valid;
    logic [SECTOR_W-1:0] writeback_sector;

    modport source (output valid, output status, output granted_slot, output need_fill,
                    output writeback_valid, output writeback_sector, input ready);
    modport sink   (input valid, input status, input granted_slot, input need_fill,
                    input writeback_valid, input writeback_sector, output ready);
endinterface

FILE: hdl/scd_ram.sv
// ----------------------------------------------------------------------------
// scd_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module scd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/sector_cache_directory_unit.sv
// ----------------------------------------------------------------------------
// sector_cache_directory_unit: fully associative sector cache directory
// lock/unlock/free/flush requests against a ram of entries, clock replacement
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  --------+-----+-------------------------------------------------------------
//  req     | in  | kind, sector, exclusive, slot, mark_dirty
//  rsp     | out | status, granted_slot, need_fill, writeback_valid,
//          |     | writeback_sector
//
//  unlock and flush read the named slot in S_SLOT, then load the response register in S_OUT
//  lock and free scan the entry ram at one read per cycle, stopping at the first
//  match; a lock that must evict adds a clock hand pass over the entries
//  after reset a clearing pass writes every entry while req.ready is low
//  one request at a time; a new request is taken while the response waits
module sector_cache_directory_unit #(
    parameter int ENTRIES     = scd_pkg::ENTRIES_DEF,
    parameter int SECTOR_BITS = scd_pkg::SECTOR_BITS_DEF,
    parameter int MAX_READERS = scd_pkg::MAX_READERS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    scd_req_if.sink   req,
    scd_rsp_if.source rsp
);
    import scd_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int RC_W  = $clog2(MAX_READERS + 1);
    localparam logic [SECTOR_BITS-1:0] NO_SECTOR = '1;

    typedef struct packed {
        logic [SECTOR_BITS-1:0] sector;
        logic [RC_W-1:0]        readers;
        logic                   writer;
        logic                   utd;
        logic                   dirty;
    } entry_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EVICT,
        S_SLOT,
        S_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       pidx_reg, pidx_next;
    logic [IDX_W-1:0]       iss_reg, iss_next;
    logic [IDX_W-1:0]       hand_reg, hand_next;
    logic                   inv_found_reg, inv_found_next;
    logic [IDX_W-1:0]       inv_idx_reg, inv_idx_next;
    kind_t                  kind_reg, kind_next;
    logic [SECTOR_BITS-1:0] sec_reg, sec_next;
    logic                   excl_reg, excl_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic                   mark_reg, mark_next;

    status_t                res_status_reg, res_status_next;
    logic [SLOT_W-1:0]      res_slot_reg, res_slot_next;
    logic                   res_fill_reg, res_fill_next;
    logic                   res_wb_reg, res_wb_next;
    logic [SECTOR_W-1:0]    res_wbsec_reg, res_wbsec_next;

    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic                   out_fill_reg, out_fill_next;
    logic                   out_wb_reg, out_wb_next;
    logic [SECTOR_W-1:0]    out_wbsec_reg, out_wbsec_next;

    logic                   ram_we, ram_re;
    logic [IDX_W-1:0]       ram_waddr, ram_raddr;
    entry_t                 wr_e, rd_e;

    logic [63:0]            sec_wide;
    logic [SECTOR_BITS-1:0] sec_in;
    logic [31:0]            slot_wide;
    logic                   slot_ok;
    logic                   accept;
    logic                   rd_idle;
    logic                   hit;
    logic                   lock_ok;
    logic                   cnt_done;
    logic [63:0]            rd_sec_wide;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        if (i == IDX_W'(ENTRIES - 1))
        begin
            return '0;
        end
        return i + IDX_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] i);
        logic [31:0] t;
        t = 32'(i);
        return t[SLOT_W-1:0];
    endfunction

    scd_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_e),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_e)
    );

    assign sec_wide    = {32'b0, req.sector};
    assign sec_in      = sec_wide[SECTOR_BITS-1:0];
    assign slot_wide   = 32'(req.slot);
    assign slot_ok     = slot_wide < 32'(ENTRIES);
    assign req.ready   = (state_reg == S_IDLE);
    assign accept      = req.valid && req.ready;
    assign rd_idle     = (rd_e.readers == '0) && !rd_e.writer;
    assign hit         = pend_reg && (rd_e.sector == sec_reg);
    assign lock_ok     = excl_reg ? rd_idle
                                  : (!rd_e.writer && (rd_e.readers < RC_W'(MAX_READERS)));
    assign cnt_done    = (cnt_reg == CNT_W'(ENTRIES));
    assign rd_sec_wide = 64'(rd_e.sector);

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.granted_slot     = out_slot_reg;
    assign rsp.need_fill        = out_fill_reg;
    assign rsp.writeback_valid  = out_wb_reg;
    assign rsp.writeback_sector = out_wbsec_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pidx_next       = pidx_reg;
        iss_next        = iss_reg;
        hand_next       = hand_reg;
        inv_found_next  = inv_found_reg;
        inv_idx_next    = inv_idx_reg;
        kind_next       = kind_reg;
        sec_next        = sec_reg;
        excl_next       = excl_reg;
        slot_next       = slot_reg;
        mark_next       = mark_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_fill_next   = res_fill_reg;
        res_wb_next     = res_wb_reg;
        res_wbsec_next  = res_wbsec_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_fill_next   = out_fill_reg;
        out_wb_next     = out_wb_reg;
        out_wbsec_next  = out_wbsec_reg;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = pidx_reg;
        ram_raddr = cnt_reg[IDX_W-1:0];
        wr_e      = rd_e;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cnt_reg[IDX_W-1:0];
                wr_e       = '{sector: NO_SECTOR, readers: '0, writer: 1'b0,
                               utd: 1'b0, dirty: 1'b0};
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next       = req.kind;
                    sec_next        = sec_in;
                    excl_next       = req.exclusive;
                    slot_next       = slot_wide[IDX_W-1:0];
                    mark_next       = req.mark_dirty;
                    cnt_next        = '0;
                    pend_next       = 1'b0;
                    inv_found_next  = 1'b0;
                    res_status_next = ST_DONE;
                    res_slot_next   = '0;
                    res_fill_next   = 1'b0;
                    res_wb_next     = 1'b0;
                    res_wbsec_next  = '0;
                    unique case (req.kind) inside
                        KIND_LOCK, KIND_FREE:
                        begin
                            if (sec_in == NO_SECTOR)
                            begin
                                res_status_next = (req.kind == KIND_LOCK) ? ST_BUSY : ST_DONE;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            if (slot_ok)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = slot_wide[IDX_W-1:0];
                                state_next = S_SLOT;
                            end
                            else
                            begin
                                state_next = S_OUT;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    // first matching entry decides, the scan stops here
                    state_next = S_OUT;
                    ram_waddr  = pidx_reg;
                    if (kind_reg == KIND_LOCK)
                    begin
                        if (lock_ok)
                        begin
                            ram_we = 1'b1;
                            if (excl_reg)
                            begin
                                wr_e.writer = 1'b1;
                            end
                            else
                            begin
                                wr_e.readers = rd_e.readers + RC_W'(1);
                            end
                            if (!rd_e.utd)
                            begin
                                wr_e.utd   = 1'b1;
                                wr_e.dirty = 1'b0;
                            end
                            res_status_next = ST_GRANTED;
                            res_slot_next   = idx_to_slot(pidx_reg);
                            res_fill_next   = !rd_e.utd;
                        end
                        else
                        begin
                            res_status_next = ST_BUSY;
                        end
                    end
                    else if (rd_idle)
                    begin
                        ram_we      = 1'b1;
                        wr_e.sector = NO_SECTOR;
                        wr_e.utd    = 1'b0;
                        wr_e.dirty  = 1'b0;
                    end
                end
                else
                begin
                    if (pend_reg && rd_e.sector == NO_SECTOR && !inv_found_reg)
                    begin
                        inv_found_next = 1'b1;
                        inv_idx_next   = pidx_reg;
                    end
                    if (!cnt_done)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = cnt_reg[IDX_W-1:0];
                        pidx_next = cnt_reg[IDX_W-1:0];
                        pend_next = 1'b1;
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                    else if (pend_reg)
                    begin
                        pend_next = 1'b0;
                    end
                    else if (kind_reg == KIND_FREE)
                    begin
                        state_next = S_OUT;
                    end
                    else if (inv_found_reg)
                    begin
                        // fresh entry holds no data yet, so a fill is due; it is marked up to date
                        ram_we          = 1'b1;
                        ram_waddr       = inv_idx_reg;
                        wr_e            = '{sector: sec_reg,
                                            readers: excl_reg ? '0 : RC_W'(1),
                                            writer: excl_reg, utd: 1'b1, dirty: 1'b0};
                        res_status_next = ST_GRANTED;
                        res_slot_next   = idx_to_slot(inv_idx_reg);
                        res_fill_next   = 1'b1;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        iss_next   = hand_reg;
                        state_next = S_EVICT;
                    end
                end
            end

            S_EVICT:
            begin
                // hand moves as each entry is examined, reads run one ahead
                if (pend_reg)
                begin
                    hand_next = idx_inc(pidx_reg);
                end
                if (pend_reg && rd_idle)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = pidx_reg;
                    wr_e.sector     = NO_SECTOR;
                    wr_e.utd        = 1'b0;
                    wr_e.dirty      = 1'b0;
                    res_status_next = ST_RETRY;
                    res_wb_next     = rd_e.utd && rd_e.dirty;
                    res_wbsec_next  = (rd_e.utd && rd_e.dirty) ? rd_sec_wide[31:0] : '0;
                    state_next      = S_OUT;
                end
                else if (!cnt_done)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = iss_reg;
                    pidx_next = iss_reg;
                    pend_next = 1'b1;
                    iss_next  = idx_inc(iss_reg);
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    res_status_next = ST_BUSY;
                    state_next      = S_OUT;
                end
            end

            S_SLOT:
            begin
                ram_waddr  = slot_reg;
                state_next = S_OUT;
                if (kind_reg == KIND_UNLOCK)
                begin
                    // a reader hold goes before a writer hold
                    if (rd_e.readers != '0)
                    begin
                        ram_we       = 1'b1;
                        wr_e.readers = rd_e.readers - RC_W'(1);
                        wr_e.dirty   = rd_e.dirty || mark_reg;
                    end
                    else if (rd_e.writer)
                    begin
                        ram_we      = 1'b1;
                        wr_e.writer = 1'b0;
                        wr_e.dirty  = rd_e.dirty || mark_reg;
                    end
                end
                else if (rd_e.sector != NO_SECTOR)
                begin
                    if (!rd_idle)
                    begin
                        res_status_next = ST_BUSY;
                    end
                    else if (rd_e.utd && rd_e.dirty)
                    begin
                        ram_we         = 1'b1;
                        wr_e.dirty     = 1'b0;
                        res_wb_next    = 1'b1;
                        res_wbsec_next = rd_sec_wide[31:0];
                    end
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_fill_next   = res_fill_reg;
                    out_wb_next     = res_wb_reg;
                    out_wbsec_next  = res_wbsec_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            pidx_reg       <= '0;
            iss_reg        <= '0;
            hand_reg       <= '0;
            inv_found_reg  <= 1'b0;
            inv_idx_reg    <= '0;
            kind_reg       <= KIND_LOCK;
            sec_reg        <= '0;
            excl_reg       <= 1'b0;
            slot_reg       <= '0;
            mark_reg       <= 1'b0;
            res_status_reg <= ST_DONE;
            res_slot_reg   <= '0;
            res_fill_reg   <= 1'b0;
            res_wb_reg     <= 1'b0;
            res_wbsec_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_DONE;
            out_slot_reg   <= '0;
            out_fill_reg   <= 1'b0;
            out_wb_reg     <= 1'b0;
            out_wbsec_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            pidx_reg       <= pidx_next;
            iss_reg        <= iss_next;
            hand_reg       <= hand_next;
            inv_found_reg  <= inv_found_next;
            inv_idx_reg    <= inv_idx_next;
            kind_reg       <= kind_next;
            sec_reg        <= sec_next;
            excl_reg       <= excl_next;
            slot_reg       <= slot_next;
            mark_reg       <= mark_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_fill_reg   <= res_fill_next;
            res_wb_reg     <= res_wb_next;
            res_wbsec_reg  <= res_wbsec_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
            out_fill_reg   <= out_fill_next;
            out_wb_reg     <= out_wb_next;
            out_wbsec_reg  <= out_wbsec_next;
        end
    end

    // writes end a scan or come in S_CLEAR or S_SLOT, so no ram read shares their cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("ram read and write in the same cycle");

    a_hand_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(hand_reg) < 32'(ENTRIES))
        else $error("clock hand out of range");

    a_grant_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_GRANTED |-> rsp.granted_slot == '0 && !rsp.need_fill)
        else $error("slot or fill set on a response that is not a grant");

    a_wb_only_retry_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.writeback_valid |->
            rsp.status == ST_RETRY || rsp.status == ST_DONE)
        else $error("write-back on a grant or busy response");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != S_IDLE)
        else $error("request accepted but sequencer stayed idle");

endmodule
